[hw/rtl/itp_pkg.sv]
// Shared types, character codes and helper functions of the infix to prefix converter.
`timescale 1ns / 1ps

package itp_pkg;

   // Character codes
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LC_A   = 8'h61;
   localparam logic [7:0] CH_LC_Z   = 8'h7A;
   localparam logic [7:0] CH_UC_A   = 8'h41;
   localparam logic [7:0] CH_UC_Z   = 8'h5A;
   localparam logic [7:0] CH_DIG_0  = 8'h30;
   localparam logic [7:0] CH_DIG_9  = 8'h39;

   typedef logic [1:0] prec_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SCAN_RD,
      ST_SCAN_LATCH,
      ST_EVAL,
      ST_REFILL_EVAL,
      ST_REFILL_SCAN,
      ST_FLUSH,
      ST_REFILL_FLUSH,
      ST_EMIT_RD,
      ST_EMIT_LOAD,
      ST_EMIT_WAIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_char;
      logic scan_rd;
      logic latch_cur;
      logic put_cur;
      logic push;
      logic pop_put;
      logic pop_drop;
      logic refill;
      logic emit_start;
      logic emit_rd;
      logic emit_load;
      logic emit_empty;
      logic finish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic k_zero;
      logic sp_zero;
      logic j_zero;
      logic cur_operand;
      logic cur_lparen;
      logic cur_rparen;
      logic top_lparen;
      logic pops;
      logic rsp_taken;
      logic rsp_last;
   } stat_type;

   function automatic prec_type prec_of(input logic [7:0] c);
      prec_type p;
      case (c)
         CH_CARET:           p = 2'd3;
         CH_STAR, CH_SLASH:  p = 2'd2;
         CH_PLUS, CH_MINUS:  p = 2'd1;
         default:            p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic is_operand(input logic [7:0] c);
      return ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
             ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
             ((c >= CH_DIG_0) && (c <= CH_DIG_9));
   endfunction

   function automatic logic [7:0] swap_paren(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         CH_LPAREN: r = CH_RPAREN;
         CH_RPAREN: r = CH_LPAREN;
         default:   r = c;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/itp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module itp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hw/rtl/itp_ctrl.sv]
// Controller state machine of the infix to prefix converter.
`timescale 1ns / 1ps

module itp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_in_last,
   input  itp_pkg::stat_type stat,
   output itp_pkg::cmd_type  cmd,
   output logic             req_stall
);
   import itp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_in_last) state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            state_in = stat.k_zero ? ST_FLUSH : ST_SCAN_LATCH;
         end
         ST_SCAN_LATCH: state_in = ST_EVAL;
         ST_EVAL: begin
            if (stat.cur_operand || stat.cur_lparen) begin
               state_in = ST_SCAN_RD;
            end else if (stat.cur_rparen) begin
               if (stat.sp_zero)         state_in = ST_SCAN_RD;
               else if (stat.top_lparen) state_in = ST_REFILL_SCAN;
               else                      state_in = ST_REFILL_EVAL;
            end else begin
               state_in = (!stat.sp_zero && stat.pops) ? ST_REFILL_EVAL : ST_SCAN_RD;
            end
         end
         ST_REFILL_EVAL:  state_in = ST_EVAL;
         ST_REFILL_SCAN:  state_in = ST_SCAN_RD;
         ST_FLUSH: begin
            state_in = stat.sp_zero ? ST_EMIT_RD : ST_REFILL_FLUSH;
         end
         ST_REFILL_FLUSH: state_in = ST_FLUSH;
         ST_EMIT_RD: begin
            state_in = stat.j_zero ? ST_EMIT_WAIT : ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD:    state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: begin
            if (stat.rsp_taken) state_in = stat.rsp_last ? ST_LOAD : ST_EMIT_RD;
         end
         default:         state_in = ST_LOAD;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall     = 1'b0;
            cmd.load_char = req_valid;
         end
         ST_SCAN_RD:    cmd.scan_rd   = !stat.k_zero;
         ST_SCAN_LATCH: cmd.latch_cur = 1'b1;
         ST_EVAL: begin
            if (stat.cur_operand) begin
               cmd.put_cur = 1'b1;
            end else if (stat.cur_lparen) begin
               cmd.push = 1'b1;
            end else if (stat.cur_rparen) begin
               if (!stat.sp_zero) begin
                  cmd.pop_drop = stat.top_lparen;
                  cmd.pop_put  = !stat.top_lparen;
               end
            end else if (!stat.sp_zero && stat.pops) begin
               cmd.pop_put = 1'b1;
            end else begin
               cmd.push = 1'b1;
            end
         end
         ST_REFILL_EVAL, ST_REFILL_SCAN, ST_REFILL_FLUSH: cmd.refill = 1'b1;
         ST_FLUSH: begin
            cmd.pop_put    = !stat.sp_zero;
            cmd.emit_start = stat.sp_zero;
         end
         ST_EMIT_RD: begin
            cmd.emit_empty = stat.j_zero;
            cmd.emit_rd    = !stat.j_zero;
         end
         ST_EMIT_LOAD: cmd.emit_load = 1'b1;
         ST_EMIT_WAIT: cmd.finish = stat.rsp_taken && stat.rsp_last;
         default: ;
      endcase
   end

endmodule

[hw/rtl/itp_dp.sv]
// Datapath of the infix to prefix converter: buffers, stack, counters, result register.
`timescale 1ns / 1ps

module itp_dp #(
   parameter int MAX_LEN = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  itp_pkg::cmd_type  cmd,
   output itp_pkg::stat_type stat,
   input  logic [7:0]        req_in_char,
   input  logic              req_in_last,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_out_last,
   output logic              rsp_out_empty,
   output logic              rsp_out_overflow
);
   import itp_pkg::*;

   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int IW = $clog2(MAX_LEN);

   logic [CW-1:0] len_ff, len_in, k_ff, k_in, sp_ff, sp_in;
   logic [CW-1:0] alen_ff, alen_in, j_ff, j_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    cur_ff, cur_in, top_ff, top_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_last_ff, rsp_last_in, rsp_empty_ff, rsp_empty_in;

   logic          has_room, rsp_taken;
   logic [CW-1:0] len_inc, k_dec, sp_dec2, j_dec;
   logic [7:0]    expr_rdata, stk_rdata, ans_rdata;
   prec_type      p_cur, p_top;

   assign has_room  = len_ff < CW'(MAX_LEN);
   assign len_inc   = len_ff + CW'(1);
   assign k_dec     = k_ff - CW'(1);
   assign sp_dec2   = sp_ff - CW'(2);
   assign j_dec     = j_ff - CW'(1);
   assign rsp_taken = rsp_valid_ff && !rsp_stall;

   itp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_expr (
      .clock   (clock),
      .wr_en   (cmd.load_char && has_room),
      .wr_addr (len_ff[IW-1:0]),
      .wr_data (req_in_char),
      .rd_en   (cmd.scan_rd),
      .rd_addr (k_dec[IW-1:0]),
      .rd_data (expr_rdata)
   );

   // Stack top lives in top_ff; a pop reads the entry below it back.
   itp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (sp_ff[IW-1:0]),
      .wr_data (cur_ff),
      .rd_en   (cmd.pop_put || cmd.pop_drop),
      .rd_addr (sp_dec2[IW-1:0]),
      .rd_data (stk_rdata)
   );

   itp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_answer (
      .clock   (clock),
      .wr_en   (cmd.put_cur || cmd.pop_put),
      .wr_addr (alen_ff[IW-1:0]),
      .wr_data (cmd.put_cur ? cur_ff : top_ff),
      .rd_en   (cmd.emit_rd),
      .rd_addr (j_dec[IW-1:0]),
      .rd_data (ans_rdata)
   );

   always_comb begin
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      k_in         = k_ff;
      sp_in        = sp_ff;
      alen_in      = alen_ff;
      j_in         = j_ff;
      cur_in       = cur_ff;
      top_in       = top_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_taken;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;

      if (cmd.load_char) begin
         if (has_room) len_in = len_inc;
         else          ovf_in = 1'b1;
         if (req_in_last) begin
            k_in    = has_room ? len_inc : len_ff;
            sp_in   = '0;
            alen_in = '0;
         end
      end
      if (cmd.scan_rd)   k_in   = k_dec;
      if (cmd.latch_cur) cur_in = swap_paren(expr_rdata);
      if (cmd.put_cur)   alen_in = alen_ff + CW'(1);
      if (cmd.push) begin
         sp_in  = sp_ff + CW'(1);
         top_in = cur_ff;
      end
      if (cmd.pop_put) begin
         alen_in = alen_ff + CW'(1);
         sp_in   = sp_ff - CW'(1);
      end
      if (cmd.pop_drop)   sp_in  = sp_ff - CW'(1);
      if (cmd.refill)     top_in = stk_rdata;
      if (cmd.emit_start) j_in   = alen_ff;
      if (cmd.emit_rd)    j_in   = j_dec;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = ans_rdata;
         rsp_last_in  = (j_ff == '0);
         rsp_empty_in = 1'b0;
      end
      if (cmd.emit_empty) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = '0;
         rsp_last_in  = 1'b1;
         rsp_empty_in = 1'b1;
      end
      if (cmd.finish) begin
         len_in = '0;
         ovf_in = 1'b0;
         sp_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         k_ff         <= '0;
         sp_ff        <= '0;
         alen_ff      <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         k_ff         <= k_in;
         sp_ff        <= sp_in;
         alen_ff      <= alen_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      top_ff       <= top_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign p_cur = prec_of(cur_ff);
   assign p_top = prec_of(top_ff);

   always_comb begin
      stat             = '0;
      stat.k_zero      = (k_ff == '0);
      stat.sp_zero     = (sp_ff == '0);
      stat.j_zero      = (j_ff == '0);
      stat.cur_operand = is_operand(cur_ff);
      stat.cur_lparen  = (cur_ff == CH_LPAREN);
      stat.cur_rparen  = (cur_ff == CH_RPAREN);
      stat.top_lparen  = (top_ff == CH_LPAREN);
      // '^' is right associative: it pops on equal precedence
      stat.pops        = (cur_ff == CH_CARET) ? (p_cur <= p_top) : (p_cur < p_top);
      stat.rsp_taken   = rsp_taken;
      stat.rsp_last    = rsp_last_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = rsp_char_ff;
   assign rsp_out_last     = rsp_last_ff;
   assign rsp_out_empty    = rsp_empty_ff;
   assign rsp_out_overflow = ovf_ff;

endmodule

[hw/rtl/infix_to_prefix_converter.sv]
// Top level of the infix to prefix converter: controller, datapath and checks.
`timescale 1ns / 1ps

// Usage:
//  - req channel: one ASCII character per item (req_in_char), req_in_last marks
//    the end of the expression. Items are taken one per cycle while loading.
//  - Up to MAX_LEN characters are stored; later ones are dropped and every
//    result item of that expression carries rsp_out_overflow.
//  - After the last item req_stall stays high while the stored expression is
//    scanned backwards with an operator stack held in a RAM (top cached in a
//    register). Each scanned character is read, latched and evaluated, and each
//    stack pop adds a refill of the top, since the RAM read behind the top is registered.
//  - rsp channel: the prefix form, one character per item, rsp_out_last on
//    the final one. An empty answer gives a single item with rsp_out_empty and
//    rsp_out_last set and rsp_out_char zero.
//  - Each result item goes through an answer RAM read, a result register load and
//    the handoff; the result register holds still while rsp_stall is high.
//  - Loading of the next expression starts once the last result is taken.
//  - Reset (synchronous, active high) clears all counters and the state machine;
//    buffer contents are not cleared and need no clearing pass.
module infix_to_prefix_converter #(
   parameter int MAX_LEN = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last,
   output logic       rsp_out_empty,
   output logic       rsp_out_overflow
);
   import itp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   itp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_last (req_in_last),
      .stat        (stat),
      .cmd         (cmd),
      .req_stall   (req_stall)
   );

   itp_dp #(.MAX_LEN(MAX_LEN)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_in_char      (req_in_char),
      .req_in_last      (req_in_last),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_char     (rsp_out_char),
      .rsp_out_last     (rsp_out_last),
      .rsp_out_empty    (rsp_out_empty),
      .rsp_out_overflow (rsp_out_overflow)
   );

   // No new characters while a result is pending
   a_no_load_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result item is pending");

   // An empty answer is always a single, final item
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_empty) |-> (rsp_out_last && (rsp_out_char == 8'd0)))
      else $error("empty result item not marked last or carries a character");

   // After the final item is taken the block is back to loading
   a_reload_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_out_last) |=> (!rsp_valid && !req_stall))
      else $error("block not ready for a new expression after the last result");

endmodule

[tb/infix_to_prefix_checker.sv]
// Checker for the infix to prefix converter: predicts the prefix answer and compares results.
`timescale 1ns / 1ps

module infix_to_prefix_checker #(
   parameter int MAX_LEN = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_char,
   input  logic       rsp_out_last,
   input  logic       rsp_out_empty,
   input  logic       rsp_out_overflow,
   output int         fail_count,
   output int         pending_count
);
   import itp_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       is_last;
      logic       is_empty;
      logic       ovf;
   } prefix_item_type;

   prefix_item_type prefix_due[$];
   logic [7:0]      infix_text[64];
   int              infix_len;
   logic            infix_dropped;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      infix_len     = 0;
      infix_dropped = 1'b0;
   end

   function automatic int bind_strength(input logic [7:0] c);
      case (c)
         CH_CARET:          return 3;
         CH_STAR, CH_SLASH: return 2;
         CH_PLUS, CH_MINUS: return 1;
         default:           return 0;
      endcase
   endfunction

   function automatic logic is_term_char(input logic [7:0] c);
      return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z) ||
             (c >= CH_DIG_0 && c <= CH_DIG_9);
   endfunction

   // Appends one expected result item at the tail of the queue.
   function automatic void queue_due(input prefix_item_type entry);
      prefix_due = {prefix_due, entry};
   endfunction

   // Reverse scan with swapped parens; rev collects the answer back to front.
   function automatic void predict_prefix();
      logic [7:0]      ops[64];
      logic [7:0]      rev[64];
      logic [7:0]      c;
      int              sp;
      int              n;
      int              p;
      prefix_item_type item;
      sp = 0;
      n  = 0;
      for (int k = infix_len; k > 0; k--) begin
         c = infix_text[k - 1];
         if (c == CH_LPAREN) c = CH_RPAREN;
         else if (c == CH_RPAREN) c = CH_LPAREN;
         if (is_term_char(c)) begin
            rev[n] = c;
            n++;
         end else if (c == CH_LPAREN) begin
            ops[sp] = c;
            sp++;
         end else if (c == CH_RPAREN) begin
            while (sp > 0 && ops[sp - 1] != CH_LPAREN) begin
               sp--;
               rev[n] = ops[sp];
               n++;
            end
            if (sp > 0) sp--;
         end else begin
            p = bind_strength(c);
            // caret is right associative: it pops on a tie, the rest do not
            while (sp > 0 && ((c == CH_CARET) ? (p <= bind_strength(ops[sp - 1]))
                                              : (p < bind_strength(ops[sp - 1])))) begin
               sp--;
               rev[n] = ops[sp];
               n++;
            end
            ops[sp] = c;
            sp++;
         end
      end
      while (sp > 0) begin
         sp--;
         rev[n] = ops[sp];
         n++;
      end
      if (n == 0) begin
         item = '{ch: 8'h00, is_last: 1'b1, is_empty: 1'b1, ovf: infix_dropped};
         queue_due(item);
      end else begin
         for (int k = n; k > 0; k--) begin
            item = '{ch: rev[k - 1], is_last: (k == 1), is_empty: 1'b0, ovf: infix_dropped};
            queue_due(item);
         end
      end
   endfunction

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      prefix_item_type want;
      if (reset) begin
         infix_len     = 0;
         infix_dropped = 1'b0;
         prefix_due.delete();
      end else begin
         // results first: a result taken at this edge belongs to an older expression
         if (rsp_valid && !rsp_stall) begin
            if (prefix_due.size() == 0) begin
               $error("unexpected result item: char %0d", rsp_out_char);
               fail_count++;
            end else begin
               want = prefix_due.pop_front();
               check_field("out_char", want.ch, rsp_out_char);
               check_field("out_last", want.is_last, rsp_out_last);
               check_field("out_empty", want.is_empty, rsp_out_empty);
               check_field("out_overflow", want.ovf, rsp_out_overflow);
            end
         end
         if (req_valid && !req_stall) begin
            if (infix_len < MAX_LEN) begin
               infix_text[infix_len] = req_in_char;
               infix_len++;
            end else begin
               infix_dropped = 1'b1;
            end
            if (req_in_last) begin
               predict_prefix();
               infix_len     = 0;
               infix_dropped = 1'b0;
            end
         end
      end
      pending_count = prefix_due.size();
   end

endmodule

[tb/tb_infix_to_prefix_converter.sv]
// Testbench top for the infix to prefix converter: stimulus, idling, timeout and verdict.
`timescale 1ns / 1ps

module tb_infix_to_prefix_converter;
   import itp_pkg::*;

   localparam int MAX_CHARS   = 64;
   localparam int CYCLE_LIMIT = 200000;  // many times the slowest correct run
   localparam int HOLD_CYCLES = 300;     // long receiver hold-off in the last phase

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_char = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_out_last;
   logic       rsp_out_empty;
   logic       rsp_out_overflow;

   int fail_count;
   int pending_count;

   // Idle percentages per phase, set by the stimulus process.
   int send_idle_pct  = 6;
   int recv_stall_pct = 87;

   // Hold-off requests: the stimulus bumps hold_ticket, the receiver counts it down.
   int hold_ticket = 0;
   int holds_done  = 0;
   int hold_left   = 0;

   int items_sent  = 0;
   int cycle_count = 0;

   always #6 clock = ~clock;

   infix_to_prefix_converter #(
      .MAX_LEN(MAX_CHARS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_char     (req_in_char),
      .req_in_last     (req_in_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_out_last    (rsp_out_last),
      .rsp_out_empty   (rsp_out_empty),
      .rsp_out_overflow(rsp_out_overflow)
   );

   infix_to_prefix_checker #(
      .MAX_LEN(MAX_CHARS)
   ) checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_char     (req_in_char),
      .req_in_last     (req_in_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_out_last    (rsp_out_last),
      .rsp_out_empty   (rsp_out_empty),
      .rsp_out_overflow(rsp_out_overflow),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   // Receiver: random stall per phase, or a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_done != hold_ticket) begin
         holds_done++;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Character pickers
   // ---------------------------------------------------------------------
   function automatic logic [7:0] term_char();
      case ($urandom_range(2))
         0:       return 8'(CH_LC_A + $urandom_range(25));
         1:       return 8'(CH_UC_A + $urandom_range(25));
         default: return 8'(CH_DIG_0 + $urandom_range(9));
      endcase
   endfunction

   // Mostly real operators; now and then a random byte, which ranks lowest if it is no operator.
   function automatic logic [7:0] op_char();
      case ($urandom_range(5))
         0:       return CH_CARET;
         1:       return CH_STAR;
         2:       return CH_SLASH;
         3:       return CH_PLUS;
         4:       return CH_MINUS;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] any_char();
      case ($urandom_range(3))
         0:       return term_char();
         1:       return op_char();
         2:       return $urandom_range(1) ? CH_LPAREN : CH_RPAREN;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Appends one character at the tail of a character queue.
   function automatic void append_char(ref logic [7:0] q[$], input logic [7:0] c);
      q = {q, c};
   endfunction

   // Well-formed infix text of at least target chars, with a little noise.
   // A trailing operator can be left when the length runs out.
   function automatic void build_formula(ref logic [7:0] q[$], input int target);
      int depth;
      depth = 0;
      q.delete();
      while (q.size() < target) begin
         while ($urandom_range(3) == 0 && q.size() < target) begin
            append_char(q, CH_LPAREN);
            depth++;
         end
         append_char(q, term_char());
         while (depth > 0 && $urandom_range(2) == 0) begin
            append_char(q, CH_RPAREN);
            depth--;
         end
         if (q.size() < target) append_char(q, op_char());
      end
      while (depth > 0) begin
         append_char(q, CH_RPAREN);
         depth--;
      end
      foreach (q[i])
         if ($urandom_range(19) == 0) q[i] = 8'($urandom_range(255));
   endfunction

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------
   // Called at a falling edge; returns at the falling edge after acceptance,
   // with valid still high so back-to-back items need no extra assignment.
   task automatic send_item(input logic [7:0] ch, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_char <= ch;
      req_in_last <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_formula(input logic [7:0] q[$]);
      foreach (q[i]) send_item(q[i], i == q.size() - 1);
   endtask

   task automatic send_text(input string s);
      logic [7:0] q[$];
      for (int i = 0; i < s.len(); i++) append_char(q, s[i]);
      send_formula(q);
   endtask

   // Full-length expression; beyond MAX_CHARS the tail is dropped, but its last mark still ends the expression.
   task automatic send_long_formula(input int n);
      logic [7:0] q[$];
      build_formula(q, n);
      while (q.size() > n) void'(q.pop_back());
      send_formula(q);
   endtask

   // Mostly short well-formed expressions; some are random junk.
   task automatic send_random_formula();
      logic [7:0] q[$];
      int         len;
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      if ($urandom_range(99) < 15) begin
         for (int i = 0; i < len; i++) append_char(q, any_char());
      end else begin
         build_formula(q, len);
      end
      send_formula(q);
   endtask

   // Sender pause until every expected result item has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [7:0] q[$];
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Phase 0: sender nearly always busy, receiver mostly stalled.
      send_idle_pct  = 6;
      recv_stall_pct = 87;

      // lone '(' swaps to a stray ')' on the scan: empty answer
      send_text("(");
      // every operator; caret ties pop, the others do not
      send_text("a/b*c-d+e^f^g");
      // parens and the operand range ends
      send_text("(A-9)/z");
      // byte extremes plus an unmatched ')' left on the stack
      q = '{CH_DIG_0, CH_RPAREN, 8'hFF, 8'h00};
      send_formula(q);

      // exactly full buffer, no overflow
      send_long_formula(MAX_CHARS);
      while (items_sent < 150) send_random_formula();
      wait_drained();

      // Phase 1: sender mostly idle, receiver rarely stalls.
      send_idle_pct  = 87;
      recv_stall_pct = 6;
      while (items_sent < 300) send_random_formula();
      wait_drained();

      // Phase 2: no idling, after a long receiver hold-off that backs up the input.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      hold_ticket++;
      @(negedge clock);
      repeat (4) send_random_formula();
      // too many chars: overflow flag on every result item
      send_long_formula(MAX_CHARS + 3);
      while (items_sent < 460) send_random_formula();
      wait_drained();

      // let any straggling result show up before the verdict
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/itp_pkg.sv
hw/rtl/itp_ram.sv
hw/rtl/itp_ctrl.sv
hw/rtl/itp_dp.sv
hw/rtl/infix_to_prefix_converter.sv
tb/infix_to_prefix_checker.sv
tb/tb_infix_to_prefix_converter.sv
